// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== sv/trme_pkg.sv =====
// ----------------------------------------------------------------------------
// trme_pkg
// Types and constants shared by the register machine execute block.
// ----------------------------------------------------------------------------
package trme_pkg;

  localparam int NumRegs      = 5;
  localparam int MemWordsDef  = 64;
  localparam int DataW        = 32;
  localparam int PcW          = 16;
  localparam int CfgPlen      = 0;
  localparam logic [PcW-1:0] PcReset   = 16'd1;
  localparam logic [PcW-1:0] PlenReset = 16'd1;

  typedef enum logic [2:0] {
    KMov = 3'd0,
    KAdd = 3'd1,
    KSub = 3'd2,
    KJmp = 3'd3,
    KJpn = 3'd4,
    KHlt = 3'd5,
    KPrn = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    SmImm = 2'd0,
    SmReg = 2'd1,
    SmMem = 2'd2
  } src_mode_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StAddr = 2'd1,
    StJump = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]       kind;
    logic             dest_is_memory;
    logic [2:0]       dest_reg;
    logic [1:0]       source_mode;
    logic [2:0]       source_reg;
    logic [DataW-1:0] immediate;
    logic [PcW-1:0]   jump_line;
    logic             jump_conditional;
    logic             aok;
    logic [DataW-1:0] rd_val;
    logic [DataW-1:0] rs_val;
    logic [DataW-1:0] mem_val;
    logic [PcW-1:0]   pc;
    logic [PcW-1:0]   plen;
  } exec_in_t;

  typedef struct packed {
    logic             reg_we;
    logic [2:0]       reg_idx;
    logic [DataW-1:0] reg_data;
    logic             mem_we;
    logic [DataW-1:0] mem_data;
    logic [PcW-1:0]   next_pc;
    status_e          status;
    logic             print_valid;
    logic [DataW-1:0] print_value;
  } exec_out_t;

endpackage

// ===== sv/trme_ram.sv =====
// ----------------------------------------------------------------------------
// trme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trme_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/trme_exec.sv =====
// ----------------------------------------------------------------------------
// trme_exec
// Combinational execute logic for one decoded instruction.
// ----------------------------------------------------------------------------
module trme_exec (
  input  trme_pkg::exec_in_t  ex_i,
  output trme_pkg::exec_out_t ex_o
);

  trme_pkg::src_mode_e sm;
  logic [trme_pkg::DataW-1:0] opnd;
  logic [trme_pkg::PcW-1:0]   inc_pc;
  logic take;

  assign inc_pc = ex_i.pc + 16'd1;

  always_comb begin
    case (ex_i.source_mode)
      trme_pkg::SmReg: sm = trme_pkg::SmReg;
      trme_pkg::SmMem: sm = trme_pkg::SmMem;
      default:         sm = trme_pkg::SmImm;
    endcase

    case (sm)
      trme_pkg::SmReg: opnd = ex_i.rs_val;
      trme_pkg::SmMem: opnd = ex_i.mem_val;
      default:         opnd = ex_i.immediate;
    endcase

    ex_o             = '0;
    ex_o.reg_idx     = ex_i.dest_reg;
    ex_o.reg_data    = ex_i.immediate;
    ex_o.mem_data    = ex_i.immediate;
    ex_o.status      = trme_pkg::StOk;
    ex_o.next_pc     = inc_pc;
    take             = 1'b0;

    unique case (trme_pkg::kind_e'(ex_i.kind))
      trme_pkg::KMov: begin
        if (!ex_i.dest_is_memory) begin
          if (sm == trme_pkg::SmImm) begin
            ex_o.reg_we = 1'b1;
          end else if (sm == trme_pkg::SmReg) begin
            ex_o.reg_we   = 1'b1;
            ex_o.reg_data = ex_i.rs_val;
          end else if (!ex_i.aok) begin
            ex_o.status = trme_pkg::StAddr;
          end else begin
            ex_o.mem_we   = 1'b1;
            ex_o.mem_data = ex_i.rd_val;
          end
        end else if (sm != trme_pkg::SmMem) begin
          if (!ex_i.aok) begin
            ex_o.status = trme_pkg::StAddr;
          end else if (sm == trme_pkg::SmImm) begin
            ex_o.mem_we = 1'b1;
          end else begin
            ex_o.reg_we   = 1'b1;
            ex_o.reg_idx  = ex_i.source_reg;
            ex_o.reg_data = ex_i.mem_val;
          end
        end
      end
      trme_pkg::KAdd, trme_pkg::KSub: begin
        if (sm == trme_pkg::SmMem && !ex_i.aok) begin
          ex_o.status = trme_pkg::StAddr;
        end else begin
          ex_o.reg_we   = 1'b1;
          ex_o.reg_data = (trme_pkg::kind_e'(ex_i.kind) == trme_pkg::KAdd) ?
                          ex_i.rd_val + opnd : ex_i.rd_val - opnd;
        end
      end
      trme_pkg::KJmp, trme_pkg::KJpn: begin
        if (!ex_i.jump_conditional) begin
          take = 1'b1;
        end else if (trme_pkg::kind_e'(ex_i.kind) == trme_pkg::KJmp) begin
          take = (ex_i.rd_val == '0);
        end else begin
          take = (ex_i.rd_val == '0) || ex_i.rd_val[trme_pkg::DataW-1];
        end
        if (take) begin
          if (ex_i.jump_line == '0 || ex_i.jump_line > ex_i.plen) begin
            ex_o.status = trme_pkg::StJump;
          end else begin
            ex_o.next_pc = ex_i.jump_line;
          end
        end
      end
      trme_pkg::KHlt: begin
        ex_o.next_pc = '0;
      end
      trme_pkg::KPrn: begin
        if (ex_i.dest_is_memory) begin
          if (!ex_i.aok) begin
            ex_o.status = trme_pkg::StAddr;
          end else begin
            ex_o.print_valid = 1'b1;
            ex_o.print_value = ex_i.mem_val;
          end
        end else begin
          ex_o.print_valid = 1'b1;
          ex_o.print_value = ex_i.rd_val;
        end
      end
      default: begin
        ex_o.next_pc = ex_i.pc;
      end
    endcase

    if (ex_o.status != trme_pkg::StOk) begin
      ex_o.next_pc = ex_i.pc;
    end
    if (ex_o.reg_idx >= 3'(trme_pkg::NumRegs)) begin
      ex_o.reg_we = 1'b0;
    end
  end

endmodule

// ===== sv/toy_register_machine_execute.sv =====
// ----------------------------------------------------------------------------
// toy_register_machine_execute
// Executes one decoded instruction per item on five registers, a data
// memory and a program counter.
// ----------------------------------------------------------------------------
// The input channel takes one decoded instruction per item and the output
// channel returns one result item for each: next PC, halt flag, status and
// an optional printed value. Both channels use valid and stall.
// An accepted item is captured in the input stage together with its register
// and memory reads; when it moves on it executes, updates the state and
// lands in the output register. One item per cycle is sustained while the
// output is not stalled; the rate is set by the combinational execute path
// between the read registers and the result register, with a one-entry bypass
// covering the write of the item ahead.
// A stall on the output holds the result register; the input stage still
// takes one more item and then stalls the input channel.
// Reset clears the PC to one, program_length to one, and the valid bits of
// the registers and data memory, so every entry reads as zero until written.
// No clearing pass is needed. program_length is written over the APB port at
// byte address 0 by the user, only while the block is idle; nothing checks it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module toy_register_machine_execute #(
  parameter int MEM_WORDS = trme_pkg::MemWordsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic               dest_is_memory_i,
  input  logic [2:0]         dest_reg_i,
  input  logic [1:0]         source_mode_i,
  input  logic [2:0]         source_reg_i,
  input  logic signed [31:0] immediate_i,
  input  logic [7:0]         address_i,
  input  logic [15:0]        jump_line_i,
  input  logic               jump_conditional_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        next_pc_o,
  output logic               halted_o,
  output logic [1:0]         status_o,
  output logic               print_valid_o,
  output logic signed [31:0] print_value_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int MemAw = $clog2(MEM_WORDS);
  localparam int RegAw = $clog2(trme_pkg::NumRegs);
  localparam int Dw    = trme_pkg::DataW;
  localparam int Pw    = trme_pkg::PcW;

  logic accept, x_move;
  logic x_valid_q;
  logic out_valid_q;

  logic [2:0]    x_kind_q, x_dreg_q, x_sreg_q;
  logic          x_dmem_q, x_jc_q, x_aok_q;
  logic [1:0]    x_sm_q;
  logic [Dw-1:0] x_imm_q;
  logic [7:0]    x_addr_q;
  logic [Pw-1:0] x_jl_q;
  logic          x_rd_ok_q, x_rs_ok_q, x_m_ok_q;

  logic [trme_pkg::NumRegs-1:0] reg_vld_q;
  logic [MEM_WORDS-1:0]         mem_vld_q;

  logic          byp_reg_we_q, byp_mem_we_q;
  logic [2:0]    byp_reg_idx_q;
  logic [Dw-1:0] byp_reg_data_q, byp_mem_data_q;
  logic [MemAw-1:0] byp_mem_addr_q;

  logic [Pw-1:0] pc_q, plen_q;

  logic [Pw-1:0] out_pc_q;
  logic [1:0]    out_status_q;
  logic          out_pv_q;
  logic [Dw-1:0] out_pval_q;

  logic [Dw-1:0] rd_ram, rs_ram, mem_ram;
  logic          in_aok;
  logic          cfg_wr;

  trme_pkg::exec_in_t  ex_in;
  trme_pkg::exec_out_t ex_out;

  assign x_move     = x_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = x_valid_q && !x_move;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_aok     = 32'(address_i) < MEM_WORDS;

  trme_ram #(.Width(Dw), .Depth(trme_pkg::NumRegs)) u_reg_a (
    .clk_i   (clk_i),
    .we_i    (x_move && ex_out.reg_we),
    .waddr_i (ex_out.reg_idx[RegAw-1:0]),
    .wdata_i (ex_out.reg_data),
    .re_i    (accept),
    .raddr_i (dest_reg_i[RegAw-1:0]),
    .rdata_o (rd_ram)
  );

  trme_ram #(.Width(Dw), .Depth(trme_pkg::NumRegs)) u_reg_b (
    .clk_i   (clk_i),
    .we_i    (x_move && ex_out.reg_we),
    .waddr_i (ex_out.reg_idx[RegAw-1:0]),
    .wdata_i (ex_out.reg_data),
    .re_i    (accept),
    .raddr_i (source_reg_i[RegAw-1:0]),
    .rdata_o (rs_ram)
  );

  trme_ram #(.Width(Dw), .Depth(MEM_WORDS)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (x_move && ex_out.mem_we),
    .waddr_i (x_addr_q[MemAw-1:0]),
    .wdata_i (ex_out.mem_data),
    .re_i    (accept),
    .raddr_i (address_i[MemAw-1:0]),
    .rdata_o (mem_ram)
  );

  always_comb begin
    ex_in.kind             = x_kind_q;
    ex_in.dest_is_memory   = x_dmem_q;
    ex_in.dest_reg         = x_dreg_q;
    ex_in.source_mode      = x_sm_q;
    ex_in.source_reg       = x_sreg_q;
    ex_in.immediate        = x_imm_q;
    ex_in.jump_line        = x_jl_q;
    ex_in.jump_conditional = x_jc_q;
    ex_in.aok              = x_aok_q;
    ex_in.pc               = pc_q;
    ex_in.plen             = plen_q;
    if (byp_reg_we_q && byp_reg_idx_q == x_dreg_q) begin
      ex_in.rd_val = byp_reg_data_q;
    end else begin
      ex_in.rd_val = x_rd_ok_q ? rd_ram : '0;
    end
    if (byp_reg_we_q && byp_reg_idx_q == x_sreg_q) begin
      ex_in.rs_val = byp_reg_data_q;
    end else begin
      ex_in.rs_val = x_rs_ok_q ? rs_ram : '0;
    end
    if (byp_mem_we_q && byp_mem_addr_q == x_addr_q[MemAw-1:0]) begin
      ex_in.mem_val = byp_mem_data_q;
    end else begin
      ex_in.mem_val = x_m_ok_q ? mem_ram : '0;
    end
  end

  trme_exec u_exec (
    .ex_i (ex_in),
    .ex_o (ex_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      reg_vld_q    <= '0;
      mem_vld_q    <= '0;
      byp_reg_we_q <= 1'b0;
      byp_mem_we_q <= 1'b0;
      pc_q         <= trme_pkg::PcReset;
      plen_q       <= trme_pkg::PlenReset;
    end else begin
      if (accept) begin
        x_valid_q <= 1'b1;
      end else if (x_move) begin
        x_valid_q <= 1'b0;
      end
      if (x_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        byp_reg_we_q <= x_move && ex_out.reg_we;
        byp_mem_we_q <= x_move && ex_out.mem_we;
      end
      if (x_move) begin
        pc_q <= ex_out.next_pc;
        if (ex_out.reg_we) begin
          reg_vld_q[ex_out.reg_idx[RegAw-1:0]] <= 1'b1;
        end
        if (ex_out.mem_we) begin
          mem_vld_q[x_addr_q[MemAw-1:0]] <= 1'b1;
        end
      end
      if (cfg_wr) begin
        plen_q <= pwdata[Pw-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_kind_q       <= kind_i;
      x_dmem_q       <= dest_is_memory_i;
      x_dreg_q       <= dest_reg_i;
      x_sm_q         <= source_mode_i;
      x_sreg_q       <= source_reg_i;
      x_imm_q        <= $unsigned(immediate_i);
      x_addr_q       <= address_i;
      x_jl_q         <= jump_line_i;
      x_jc_q         <= jump_conditional_i;
      x_aok_q        <= in_aok;
      x_rd_ok_q      <= (dest_reg_i < 3'(trme_pkg::NumRegs)) ?
                        reg_vld_q[dest_reg_i[RegAw-1:0]] : 1'b0;
      x_rs_ok_q      <= (source_reg_i < 3'(trme_pkg::NumRegs)) ?
                        reg_vld_q[source_reg_i[RegAw-1:0]] : 1'b0;
      x_m_ok_q       <= in_aok ? mem_vld_q[address_i[MemAw-1:0]] : 1'b0;
      byp_reg_idx_q  <= ex_out.reg_idx;
      byp_reg_data_q <= ex_out.reg_data;
      byp_mem_addr_q <= x_addr_q[MemAw-1:0];
      byp_mem_data_q <= ex_out.mem_data;
    end
    if (x_move) begin
      out_pc_q     <= ex_out.next_pc;
      out_status_q <= ex_out.status;
      out_pv_q     <= ex_out.print_valid;
      out_pval_q   <= ex_out.print_value;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = out_pc_q;
  assign halted_o      = (out_pc_q == '0);
  assign status_o      = out_status_q;
  assign print_valid_o = out_pv_q;
  assign print_value_o = $signed(out_pval_q);

  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'(trme_pkg::CfgPlen));
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'(trme_pkg::CfgPlen)) ? {16'd0, plen_q} : '0;

  `ASSERT_PROP(a_move_fills_out, clk_i, rst_ni, x_move |=> out_valid_q)
  `ASSERT_NEVER(a_stall_only_when_full, clk_i, rst_ni, in_stall_o && !x_valid_q)
  `ASSERT_PROP(a_error_keeps_pc, clk_i, rst_ni,
    (x_move && ex_out.status != trme_pkg::StOk) |=> (pc_q == $past(pc_q)))
  `ASSERT_PROP(a_print_only_ok, clk_i, rst_ni,
    (out_valid_q && out_pv_q) |-> (out_status_q == trme_pkg::StOk))

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the register machine execute block. A short table
// of directed instructions is followed by random instruction streams under
// several program lengths. Each accepted instruction is run through a local
// model of the machine state; each result is checked against it or a table row.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trme_pkg::*;

  localparam logic [2:0] KindRsvd = 3'd7;
  localparam logic [1:0] SmAlias  = 2'd3;
  localparam int NumRows = 26;
  localparam int RandPerLen = 250;

  typedef struct packed {
    logic [2:0]  kind;
    logic        dest_is_memory;
    logic [2:0]  dest_reg;
    logic [1:0]  source_mode;
    logic [2:0]  source_reg;
    logic [31:0] immediate;
    logic [7:0]  address;
    logic [15:0] jump_line;
    logic        jump_conditional;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        halted;
    status_e     status;
    logic        print_valid;
    logic [31:0] print_value;
  } outcome_t;

  typedef struct packed {
    instr_t   ins;
    logic     known;
    outcome_t want;
  } directed_row_t;

  localparam outcome_t NoWant = '{16'd0, 1'b0, StOk, 1'b0, 32'd0};

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = '0;
  logic        dest_is_memory_i = 1'b0;
  logic [2:0]  dest_reg_i = '0;
  logic [1:0]  source_mode_i = '0;
  logic [2:0]  source_reg_i = '0;
  logic signed [31:0] immediate_i = '0;
  logic [7:0]  address_i = '0;
  logic [15:0] jump_line_i = '0;
  logic        jump_conditional_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] next_pc_o;
  logic        halted_o;
  logic [1:0]  status_o;
  logic        print_valid_o;
  logic signed [31:0] print_value_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  toy_register_machine_execute dut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  logic [31:0] regs_q [NumRegs];
  logic [31:0] dmem_q [MemWordsDef];
  logic [15:0] pc_q = PcReset;
  logic [15:0] plen_q = PlenReset;
  outcome_t    results_due [$];
  int          errors = 0;
  int          accepted_cnt = 0;
  bit          idle_on = 1'b1;
  bit          held_long = 1'b0;

  directed_row_t walk_rows [NumRows] = '{
    '{'{KPrn, 1'b0, 3'd0, SmImm, 3'd0, 32'h0, 8'd0, 16'd0, 1'b0},
      1'b1, '{16'd2, 1'b0, StOk, 1'b1, 32'h0}},
    '{'{KMov, 1'b0, 3'd0, SmImm, 3'd0, 32'h7fff_ffff, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KMov, 1'b0, 3'd1, SmImm, 3'd0, 32'h8000_0000, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KAdd, 1'b0, 3'd0, SmReg, 3'd1, 32'h0, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KSub, 1'b0, 3'd0, SmImm, 3'd0, 32'hffff_ffff, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KMov, 1'b1, 3'd0, SmImm, 3'd0, 32'hffff_ffff, 8'd63, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KMov, 1'b0, 3'd1, SmMem, 3'd0, 32'h0, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KMov, 1'b1, 3'd0, SmReg, 3'd4, 32'h0, 8'd63, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KMov, 1'b1, 3'd0, SmMem, 3'd0, 32'h0, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KMov, 1'b1, 3'd0, SmImm, 3'd0, 32'h5, 8'd255, 16'd0, 1'b0},
      1'b1, '{16'd10, 1'b0, StAddr, 1'b0, 32'h0}},
    '{'{KAdd, 1'b0, 3'd0, SmMem, 3'd0, 32'h0, 8'd64, 16'd0, 1'b0},
      1'b1, '{16'd10, 1'b0, StAddr, 1'b0, 32'h0}},
    '{'{KPrn, 1'b1, 3'd0, SmImm, 3'd0, 32'h0, 8'd128, 16'd0, 1'b0},
      1'b1, '{16'd10, 1'b0, StAddr, 1'b0, 32'h0}},
    '{'{KJmp, 1'b0, 3'd0, SmImm, 3'd0, 32'h0, 8'd0, 16'd0, 1'b0},
      1'b1, '{16'd10, 1'b0, StJump, 1'b0, 32'h0}},
    '{'{KJmp, 1'b0, 3'd0, SmImm, 3'd0, 32'h0, 8'd0, 16'd1, 1'b0},
      1'b1, '{16'd1, 1'b0, StOk, 1'b0, 32'h0}},
    '{'{KJpn, 1'b0, 3'd1, SmImm, 3'd0, 32'h0, 8'd0, 16'hffff, 1'b1},
      1'b1, '{16'd1, 1'b0, StJump, 1'b0, 32'h0}},
    '{'{KJmp, 1'b0, 3'd1, SmImm, 3'd0, 32'h0, 8'd0, 16'hffff, 1'b1}, 1'b0, NoWant},
    '{'{KHlt, 1'b0, 3'd0, SmImm, 3'd0, 32'h0, 8'd0, 16'd0, 1'b0},
      1'b1, '{16'd0, 1'b1, StOk, 1'b0, 32'h0}},
    '{'{KPrn, 1'b0, 3'd4, SmImm, 3'd0, 32'h0, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KindRsvd, 1'b1, 3'd7, SmAlias, 3'd7, 32'hffff_ffff, 8'd255, 16'hffff, 1'b1},
      1'b0, NoWant},
    '{'{KAdd, 1'b0, 3'd2, SmAlias, 3'd0, 32'h10, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KMov, 1'b0, 3'd7, SmImm, 3'd0, 32'd123, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KPrn, 1'b0, 3'd7, SmImm, 3'd0, 32'h0, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KSub, 1'b0, 3'd3, SmMem, 3'd0, 32'h0, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KMov, 1'b0, 3'd2, SmReg, 3'd7, 32'h0, 8'd0, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KPrn, 1'b1, 3'd0, SmImm, 3'd0, 32'h0, 8'd63, 16'd0, 1'b0}, 1'b0, NoWant},
    '{'{KJmp, 1'b0, 3'd0, SmImm, 3'd0, 32'h0, 8'd0, 16'd1, 1'b1}, 1'b0, NoWant}
  };

  function automatic logic [31:0] reg_load(logic [2:0] idx);
    return (idx < NumRegs) ? regs_q[idx] : 32'd0;
  endfunction

  function automatic void reg_store(logic [2:0] idx, logic [31:0] val);
    if (idx < NumRegs) begin
      regs_q[idx] = val;
    end
  endfunction

  function automatic outcome_t execute_instr(instr_t it);
    outcome_t    r;
    logic [1:0]  mode;
    logic        addr_ok;
    logic        taken;
    logic [31:0] opnd;
    logic [31:0] v;
    logic [15:0] nxt;
    mode = (it.source_mode == SmAlias) ? 2'(SmImm) : it.source_mode;
    addr_ok = (it.address < MemWordsDef);
    r = NoWant;
    nxt = pc_q + 16'd1;
    case (it.kind)
      KMov: begin
        if (!it.dest_is_memory) begin
          if (mode == SmImm) begin
            reg_store(it.dest_reg, it.immediate);
          end else if (mode == SmReg) begin
            reg_store(it.dest_reg, reg_load(it.source_reg));
          end else if (!addr_ok) begin
            r.status = StAddr;
          end else begin
            dmem_q[it.address] = reg_load(it.dest_reg);
          end
        end else if (mode != SmMem) begin
          if (!addr_ok) begin
            r.status = StAddr;
          end else if (mode == SmImm) begin
            dmem_q[it.address] = it.immediate;
          end else begin
            reg_store(it.source_reg, dmem_q[it.address]);
          end
        end
      end
      KAdd, KSub: begin
        if (mode == SmMem && !addr_ok) begin
          r.status = StAddr;
        end else begin
          if (mode == SmImm) begin
            opnd = it.immediate;
          end else if (mode == SmReg) begin
            opnd = reg_load(it.source_reg);
          end else begin
            opnd = dmem_q[it.address];
          end
          v = reg_load(it.dest_reg);
          reg_store(it.dest_reg, (it.kind == KAdd) ? v + opnd : v - opnd);
        end
      end
      KJmp, KJpn: begin
        v = reg_load(it.dest_reg);
        if (!it.jump_conditional) begin
          taken = 1'b1;
        end else if (it.kind == KJmp) begin
          taken = (v == 32'd0);
        end else begin
          taken = (v == 32'd0) || v[31];
        end
        if (taken) begin
          if (it.jump_line == 16'd0 || it.jump_line > plen_q) begin
            r.status = StJump;
          end else begin
            nxt = it.jump_line;
          end
        end
      end
      KHlt: begin
        nxt = 16'd0;
      end
      KPrn: begin
        if (!it.dest_is_memory) begin
          r.print_valid = 1'b1;
          r.print_value = reg_load(it.dest_reg);
        end else if (!addr_ok) begin
          r.status = StAddr;
        end else begin
          r.print_valid = 1'b1;
          r.print_value = dmem_q[it.address];
        end
      end
      default: begin
        nxt = pc_q;
      end
    endcase
    if (r.status != StOk) begin
      nxt = pc_q;
    end
    pc_q = nxt;
    r.next_pc = nxt;
    r.halted = (nxt == 16'd0);
    return r;
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    it.kind = ($urandom_range(0, 40) == 0) ? KindRsvd : 3'($urandom_range(0, 6));
    it.dest_is_memory = 1'($urandom_range(0, 1));
    it.dest_reg = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
    it.source_mode = 2'($urandom_range(0, 3));
    it.source_reg = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
    case ($urandom_range(0, 7))
      0: it.immediate = 32'd0;
      1: it.immediate = 32'h7fff_ffff;
      2: it.immediate = 32'h8000_0000;
      3: it.immediate = 32'hffff_ffff;
      4: it.immediate = 32'($urandom_range(0, 15));
      default: it.immediate = $urandom;
    endcase
    case ($urandom_range(0, 19))
      0, 1, 2: it.address = 8'($urandom_range(MemWordsDef, 255));
      3, 4, 5, 6, 7, 8, 9: it.address = 8'($urandom_range(0, MemWordsDef - 1));
      default: it.address = 8'($urandom_range(0, 7));
    endcase
    case ($urandom_range(0, 7))
      0: it.jump_line = 16'd0;
      1: it.jump_line = 16'd1;
      2: it.jump_line = plen_q;
      3: it.jump_line = plen_q + 16'd1;
      4: it.jump_line = 16'hffff;
      5: it.jump_line = 16'($urandom_range(1, plen_q));
      default: it.jump_line = 16'($urandom_range(0, 65535));
    endcase
    it.jump_conditional = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic offer_instr(instr_t it, logic known, outcome_t want);
    outcome_t r;
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i <= it.kind;
    dest_is_memory_i <= it.dest_is_memory;
    dest_reg_i <= it.dest_reg;
    source_mode_i <= it.source_mode;
    source_reg_i <= it.source_reg;
    immediate_i <= it.immediate;
    address_i <= it.address;
    jump_line_i <= it.jump_line;
    jump_conditional_i <= it.jump_conditional;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = execute_instr(it);
    results_due.push_back(known ? want : r);
    accepted_cnt++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_program_length(logic [15:0] len);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(CfgPlen * 4);
    pwdata <= {16'd0, len};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    plen_q = len;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== len) begin
      $error("program_length: expected %0d, got %0d", len, prdata[15:0]);
      errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $error("result item with no instruction pending");
        errors++;
      end else begin
        e = results_due.pop_front();
        if (next_pc_o !== e.next_pc) begin
          $error("next_pc: expected %0d, got %0d", e.next_pc, next_pc_o);
          errors++;
        end
        if (halted_o !== e.halted) begin
          $error("halted: expected %0b, got %0b", e.halted, halted_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          errors++;
        end
        if (print_valid_o !== e.print_valid) begin
          $error("print_valid: expected %0b, got %0b", e.print_valid, print_valid_o);
          errors++;
        end
        if (print_value_o !== e.print_value) begin
          $error("print_value: expected %h, got %h", e.print_value, print_value_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_long && accepted_cnt >= 300) begin
        held_long = 1'b1;
        out_stall_i <= 1'b1;
        repeat (80) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 13);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #5ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    logic [15:0] len;
    foreach (regs_q[i]) regs_q[i] = 32'd0;
    foreach (dmem_q[i]) dmem_q[i] = 32'd0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (walk_rows[i]) begin
      offer_instr(walk_rows[i].ins, walk_rows[i].known, walk_rows[i].want);
    end
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: len = 16'hffff;
        1: len = 16'($urandom_range(2, 40));
        2: len = 16'd1;
        default: len = 16'($urandom_range(1, 65535));
      endcase
      write_program_length(len);
      for (int k = 0; k < RandPerLen; k++) begin
        if (ph == 3 && k == RandPerLen - 100) begin
          idle_on = 1'b0;
        end
        offer_instr(random_instr(), 1'b0, NoWant);
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/trme_pkg.sv
sv/trme_ram.sv
sv/trme_exec.sv
sv/toy_register_machine_execute.sv
tb/sv/tb_top.sv
